// ===== design/rcp_pkg.sv =====
// Package for the rectangle canvas painter: sizes, codes, word layouts and
// the fixed-point truncation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcp_pkg;

   // Canvas geometry and coordinate format.
   localparam int MAX_SIDE        = 256;
   localparam int COORD_FRAC_BITS = 8;
   localparam int COORD_W         = 19;
   localparam int SUM_W           = COORD_W + 1;
   localparam int EDGE_W          = SUM_W - COORD_FRAC_BITS + 1;
   localparam int IDX_W           = $clog2(MAX_SIDE);
   localparam int ADDR_W          = 2 * IDX_W;
   localparam int SCALED_W        = IDX_W + COORD_FRAC_BITS + 1;
   localparam int CMP_W           = (SCALED_W > SUM_W) ? SCALED_W : SUM_W;
   localparam int CFG_W           = 9;
   localparam int PIX_W           = 8;
   localparam int RD_W            = 8;

   localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(2 ** COORD_FRAC_BITS);

   // Register reset values.
   localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(256);
   localparam logic [PIX_W-1:0] BG_RESET   = PIX_W'(32);
   localparam logic [CFG_W-1:0] SIDE_MAX   = CFG_W'(MAX_SIDE);

   // Configuration port.
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BACKGROUND    = 2'd2;

   // Request word layout, lowest bit first.
   localparam int X_LSB    = 0;
   localparam int Y_LSB    = X_LSB + COORD_W;
   localparam int W_LSB    = Y_LSB + COORD_W;
   localparam int H_LSB    = W_LSB + COORD_W;
   localparam int PAINT_LSB = H_LSB + COORD_W;
   localparam int ROW_LSB  = PAINT_LSB + PIX_W;
   localparam int COL_LSB  = ROW_LSB + RD_W;
   localparam int REQ_USED = COL_LSB + RD_W;
   localparam int REQ_DW   = ((REQ_USED + 7) / 8) * 8;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_FILL    = 2'd1,
      REQ_OUTLINE = 2'd2,
      REQ_READ    = 2'd3
   } rcp_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } rcp_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_READ,
      ST_DONE
   } rcp_state_type;

   // One request word, unpacked.
   typedef struct packed {
      rcp_kind_type               kind;
      logic signed [COORD_W-1:0]  rect_x;
      logic signed [COORD_W-1:0]  rect_y;
      logic signed [COORD_W-1:0]  rect_width;
      logic signed [COORD_W-1:0]  rect_height;
      logic [PIX_W-1:0]           paint_char;
      logic [RD_W-1:0]            read_row;
      logic [RD_W-1:0]            read_col;
   } rcp_req_type;

   // One result word.
   typedef struct packed {
      logic [1:0]       status;
      logic [PIX_W-1:0] pixel;
   } rcp_res_type;

   // Rectangle bounds held for the length of a draw sweep.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [EDGE_W-1:0]  xe;
      logic signed [EDGE_W-1:0]  x1;
      logic signed [EDGE_W-1:0]  ye;
      logic signed [EDGE_W-1:0]  y1;
      logic                      outline;
   } rcp_edges_type;

   // Canvas memory access for one cycle.
   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } rcp_mem_req_type;

   // Fixed-point to integer, truncating toward zero.
   function automatic logic signed [EDGE_W-1:0] trunc_q(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W:0] wide;
      logic [SUM_W:0]        mag;
      wide = (SUM_W + 1)'(v);
      mag  = $unsigned(-wide) >> COORD_FRAC_BITS;
      if (v[SUM_W-1]) begin
         return -$signed(EDGE_W'(mag));
      end
      return EDGE_W'(wide >>> COORD_FRAC_BITS);
   endfunction

endpackage

`default_nettype wire

// ===== design/rectangle_canvas_painter.sv =====
// Top level of the rectangle canvas painter: configuration registers,
// request unpacking, result register. Depends on rcp_pkg, rcp_engine,
// rcp_canvas_ram.
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     tuser: kind; tdata: rectangle, paint, read address
//   rsp      out        rsp_tvalid/tready     tuser: status; tdata: pixel
//   csr      in         psel/penable/pready   canvas width, canvas height, background
//
// One word is in work at a time. A clear sweeps all 65536 pixels, a draw sweeps
// rows-in-use times columns-in-use pixels, a read reads one pixel, and a refused
// draw, a draw on an empty canvas or a read outside the canvas touches none.
// Each then posts its result from the done state and goes idle before the next
// word is taken. The single canvas memory port writes or reads one pixel per cycle.
// After reset a clearing pass over all 65536 pixels fills the canvas with the reset
// background; no request word is taken until it ends, register writes are.
// A stalled result holds in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_canvas_painter
   import rcp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // tdata: rect_x, rect_y, rect_width, rect_height, paint_char, read_row, read_col, zero pad
   input  wire logic [REQ_DW-1:0] req_tdata,
   // tuser: req_type
   input  wire logic [1:0]        req_tuser,
   // Result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // tdata: pixel
   output logic [PIX_W-1:0]       rsp_tdata,
   // tuser: status
   output logic [1:0]             rsp_tuser,
   // Configuration port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0] bg_ff;
   logic [CFG_W-1:0] cols_used, rows_used;
   logic [1:0]       reg_idx;
   logic             csr_write;

   rcp_req_type      req;
   logic             start, eng_ready, res_valid, res_ready;
   rcp_res_type      res;
   rcp_mem_req_type  mem_req;
   logic [PIX_W-1:0] rd_data;

   logic             rsp_valid_ff;
   rcp_res_type      rsp_ff;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIDE_RESET;
         height_ff <= SIDE_RESET;
         bg_ff     <= BG_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_CANVAS_WIDTH:  width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_CANVAS_HEIGHT: height_ff <= csr_pwdata[CFG_W-1:0];
            REG_BACKGROUND:    bg_ff     <= csr_pwdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CANVAS_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_CANVAS_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         REG_BACKGROUND:    csr_prdata = CSR_DW'(bg_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Sizes in use, saturated at the canvas side.
   assign cols_used = (width_ff > SIDE_MAX) ? SIDE_MAX : width_ff;
   assign rows_used = (height_ff > SIDE_MAX) ? SIDE_MAX : height_ff;

   // Request word unpacking.
   assign req.kind        = rcp_kind_type'(req_tuser);
   assign req.rect_x      = req_tdata[X_LSB +: COORD_W];
   assign req.rect_y      = req_tdata[Y_LSB +: COORD_W];
   assign req.rect_width  = req_tdata[W_LSB +: COORD_W];
   assign req.rect_height = req_tdata[H_LSB +: COORD_W];
   assign req.paint_char  = req_tdata[PAINT_LSB +: PIX_W];
   assign req.read_row    = req_tdata[ROW_LSB +: RD_W];
   assign req.read_col    = req_tdata[COL_LSB +: RD_W];

   assign req_tready = eng_ready;
   assign start      = req_tvalid && eng_ready;

   rcp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .cols_used  (cols_used),
      .rows_used  (rows_used),
      .background (bg_ff),
      .ready      (eng_ready),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   rcp_canvas_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Result register.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.pixel;
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire

// ===== design/rcp_canvas_ram.sv =====
// Canvas store: one synchronous single-port memory, one byte per pixel,
// registered read data. Depends on rcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcp_canvas_ram
   import rcp_pkg::*;
(
   input  wire logic            clock,
   input  wire rcp_mem_req_type mem_req,
   output logic [PIX_W-1:0]     rd_data
);

   logic [PIX_W-1:0] canvas_ff [0:(2**ADDR_W)-1];
   logic [PIX_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         canvas_ff[mem_req.addr] <= mem_req.wdata;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= canvas_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rcp_cover.sv =====
// Coverage test for one pixel against the held rectangle bounds, fill or
// outline. Depends on rcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcp_cover
   import rcp_pkg::*;
(
   input  wire logic [IDX_W-1:0] row,
   input  wire logic [IDX_W-1:0] col,
   input  wire rcp_edges_type    edges,
   output logic                  hit
);

   logic signed [CMP_W-1:0] col_v, row_v, col_s, row_s;
   logic signed [CMP_W-1:0] x_v, y_v, xe_v, x1_v, ye_v, y1_v;
   logic                    col_in, row_in, border;

   // Pixel indexes as integers and in fixed point.
   assign col_v = $signed(CMP_W'(col));
   assign row_v = $signed(CMP_W'(row));
   assign col_s = col_v <<< COORD_FRAC_BITS;
   assign row_s = row_v <<< COORD_FRAC_BITS;

   // Bounds widened to the compare width.
   assign x_v  = CMP_W'(edges.x);
   assign y_v  = CMP_W'(edges.y);
   assign xe_v = CMP_W'(edges.xe);
   assign x1_v = CMP_W'(edges.x1);
   assign ye_v = CMP_W'(edges.ye);
   assign y1_v = CMP_W'(edges.y1);

   // Inside test per axis, then the border test for outlines.
   assign col_in = (col_s >= x_v) && (col_v <= xe_v);
   assign row_in = (row_s >= y_v) && (row_v <= ye_v);
   assign border = (col_v <= x1_v) || (col_v >= xe_v) || (row_v <= y1_v) || (row_v >= ye_v);
   assign hit    = col_in && row_in && (!edges.outline || border);

endmodule

`default_nettype wire

// ===== design/rcp_engine.sv =====
// Request sequencer: reset clearing pass, clear and draw sweeps over the
// canvas memory, pixel reads. Depends on rcp_pkg and rcp_cover.
`timescale 1ns / 1ps
`default_nettype none

module rcp_engine
   import rcp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire rcp_req_type      req,
   input  wire logic [CFG_W-1:0] cols_used,
   input  wire logic [CFG_W-1:0] rows_used,
   input  wire logic [PIX_W-1:0] background,
   output logic                  ready,
   output rcp_mem_req_type       mem_req,
   input  wire logic [PIX_W-1:0] rd_data,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output rcp_res_type           res
);

   rcp_state_type    state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [PIX_W-1:0] data_ff, data_in;
   rcp_edges_type    edges_ff, edges_in;
   logic [1:0]       status_ff, status_in;
   logic             is_read_ff, is_read_in;

   logic             bad_size, outside, empty, hit;
   logic             col_last, row_last, sweep_last, draw_last;

   // Request classification at accept time.
   assign bad_size = req.rect_width[COORD_W-1] || (req.rect_width == '0)
                  || req.rect_height[COORD_W-1] || (req.rect_height == '0);
   assign outside  = (CFG_W'(req.read_row) >= rows_used) || (CFG_W'(req.read_col) >= cols_used);
   assign empty    = (rows_used == '0) || (cols_used == '0);

   // Sweep end conditions.
   assign sweep_last = &{row_ff, col_ff};
   assign col_last   = (CFG_W'(col_ff) + CFG_W'(1)) == cols_used;
   assign row_last   = (CFG_W'(row_ff) + CFG_W'(1)) == rows_used;
   assign draw_last  = col_last && row_last;

   // Pixel coverage for the current sweep position.
   rcp_cover u_cover (
      .row   (row_ff),
      .col   (col_ff),
      .edges (edges_ff),
      .hit   (hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req.kind)
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_READ:  state_in = outside ? ST_DONE : ST_READ;
                  default:   state_in = (bad_size || empty) ? ST_DONE : ST_DRAW;
               endcase
            end
         end
         ST_CLEAR: begin
            if (sweep_last) state_in = ST_DONE;
         end
         ST_DRAW: begin
            if (draw_last) state_in = ST_DONE;
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and memory access.
   always_comb begin
      ready         = 1'b0;
      res_valid     = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.addr  = {row_ff, col_ff};
      mem_req.wdata = data_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: mem_req.we = 1'b1;
         ST_IDLE:           ready = 1'b1;
         ST_DRAW:           mem_req.we = hit;
         ST_READ:           mem_req.re = 1'b1;
         ST_DONE:           res_valid = 1'b1;
         default:           ready = 1'b0;
      endcase
   end

   // Sweep position and write data.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      data_in = data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.kind == REQ_READ) begin
                  row_in = IDX_W'(req.read_row);
                  col_in = IDX_W'(req.read_col);
               end else begin
                  row_in = '0;
                  col_in = '0;
               end
               data_in = (req.kind == REQ_CLEAR) ? background : req.paint_char;
            end
         end
         ST_INIT, ST_CLEAR: {row_in, col_in} = {row_ff, col_ff} + ADDR_W'(1);
         ST_DRAW: begin
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + IDX_W'(1);
            end else begin
               col_in = col_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Bounds and result code, captured when a request is taken.
   always_comb begin
      edges_in   = edges_ff;
      status_in  = status_ff;
      is_read_in = is_read_ff;
      if (start) begin
         edges_in.x       = req.rect_x;
         edges_in.y       = req.rect_y;
         edges_in.xe      = trunc_q(SUM_W'(req.rect_x) + SUM_W'(req.rect_width));
         edges_in.ye      = trunc_q(SUM_W'(req.rect_y) + SUM_W'(req.rect_height));
         edges_in.x1      = trunc_q(SUM_W'(req.rect_x) + ONE_Q);
         edges_in.y1      = trunc_q(SUM_W'(req.rect_y) + ONE_Q);
         edges_in.outline = (req.kind == REQ_OUTLINE);
         is_read_in       = (req.kind == REQ_READ) && !outside;
         case (req.kind)
            REQ_CLEAR: status_in = STATUS_OK;
            REQ_READ:  status_in = outside ? STATUS_OUTSIDE : STATUS_OK;
            default:   status_in = bad_size ? STATUS_BAD_SIZE : STATUS_OK;
         endcase
      end
   end

   // Control registers; the reset pass fills with the reset background.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         data_ff  <= BG_RESET;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         data_ff  <= data_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      edges_ff   <= edges_in;
      status_ff  <= status_in;
      is_read_ff <= is_read_in;
   end

   assign res.status = status_ff;
   assign res.pixel  = is_read_ff ? rd_data : '0;

endmodule

`default_nettype wire

// ===== design/rcp_checker.sv =====
// Port-level checks for the rectangle canvas painter, bound to the top
// level. Depends on rcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcp_checker
   import rcp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [PIX_W-1:0]  rsp_tdata,
   input wire logic [1:0]        rsp_tuser
);

   // The clearing pass follows reset, so no word is taken right after it.
   a_init_busy: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during the reset clearing pass");

   // One word at a time: a taken word closes the request side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   // Only a good read carries a pixel.
   a_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == '0))
      else $error("pixel nonzero on a failed request");

   // No status code beyond the defined ones.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK) || (rsp_tuser == STATUS_BAD_SIZE)
                     || (rsp_tuser == STATUS_OUTSIDE))
      else $error("undefined status code");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

endmodule

bind rectangle_canvas_painter rcp_checker u_rcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for rectangle_canvas_painter: drives request words and
// register writes, predicts every result word and compares it at the output.
// Depends on rcp_pkg and the rectangle_canvas_painter RTL.
`timescale 1ns / 1ps

module tb_top;
   import rcp_pkg::*;

   localparam int FIX_ONE        = 1 << COORD_FRAC_BITS;
   localparam int TIMEOUT_CYCLES = 4_000_000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 16;

   // Mirror of the canvas and its registers, plus the results still owed by the block.
   class canvas_tracker;
      logic [PIX_W-1:0] canvas_mem [MAX_SIDE*MAX_SIDE];
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [PIX_W-1:0] background_reg;
      rcp_res_type      pending_results [$];
      int               mismatches;
      int               checked;
      int               reads;
      int               draws;
      int               rejected;
      int               clears;

      function new();
         width_reg      = SIDE_RESET;
         height_reg     = SIDE_RESET;
         background_reg = BG_RESET;
         foreach (canvas_mem[i]) canvas_mem[i] = BG_RESET;
         mismatches = 0;
         checked    = 0;
         reads      = 0;
         draws      = 0;
         rejected   = 0;
         clears     = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void set_register(logic [1:0] index, logic [CFG_W-1:0] value);
         case (index)
            REG_CANVAS_WIDTH:  width_reg = value;
            REG_CANVAS_HEIGHT: height_reg = value;
            REG_BACKGROUND:    background_reg = value[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Sizes above the store's side are clipped to it.
      function int in_use(logic [CFG_W-1:0] side);
         return (side > MAX_SIDE) ? MAX_SIDE : int'(side);
      endfunction

      // Fixed point to whole pixels, rounding toward zero.
      function int to_whole(int v);
         return (v >= 0) ? (v >>> COORD_FRAC_BITS) : -((-v) >>> COORD_FRAC_BITS);
      endfunction

      // Apply one accepted request word to the mirror and queue its result.
      function void note_request(rcp_req_type rq);
         rcp_res_type res;
         int cols, rows, x, y, w, h, xe, ye, x1, y1, r, c;
         bit hit;
         cols       = in_use(width_reg);
         rows       = in_use(height_reg);
         res.status = STATUS_OK;
         res.pixel  = '0;
         case (rq.kind)
            REQ_CLEAR: begin
               clears++;
               foreach (canvas_mem[i]) canvas_mem[i] = background_reg;
            end
            REQ_READ: begin
               reads++;
               if (int'(rq.read_row) >= rows || int'(rq.read_col) >= cols) begin
                  res.status = STATUS_OUTSIDE;
               end else begin
                  res.pixel = canvas_mem[int'(rq.read_row) * MAX_SIDE + int'(rq.read_col)];
               end
            end
            default: begin
               draws++;
               x = rq.rect_x;
               y = rq.rect_y;
               w = rq.rect_width;
               h = rq.rect_height;
               if (w <= 0 || h <= 0) begin
                  rejected++;
                  res.status = STATUS_BAD_SIZE;
               end else begin
                  xe = to_whole(x + w);
                  ye = to_whole(y + h);
                  x1 = to_whole(x + FIX_ONE);
                  y1 = to_whole(y + FIX_ONE);
                  for (r = 0; r < rows; r++) begin
                     if (r * FIX_ONE >= y && r <= ye) begin
                        for (c = 0; c < cols; c++) begin
                           hit = (c * FIX_ONE >= x) && (c <= xe);
                           // An outline keeps only the pixels near an edge.
                           if (hit && rq.kind == REQ_OUTLINE) begin
                              hit = (c <= x1) || (c >= xe) || (r <= y1) || (r >= ye);
                           end
                           if (hit) canvas_mem[r * MAX_SIDE + c] = rq.paint_char;
                        end
                     end
                  end
               end
            end
         endcase
         pending_results.push_back(res);
      endfunction

      // Compare one result word with the oldest outstanding expectation.
      function void check_result(logic [1:0] status, logic [PIX_W-1:0] pixel);
         rcp_res_type want;
         checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR: unexpected result word, status %0d pixel 0x%02h",
                        status, pixel);
            end
         end else begin
            want = pending_results.pop_front();
            if (status !== want.status || pixel !== want.pixel) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR: result %0d: expected status %0d pixel 0x%02h, got status %0d pixel 0x%02h",
                           checked, want.status, want.pixel, status, pixel);
               end
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata   = '0;
   logic [1:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [PIX_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   canvas_tracker tracker = new();
   bit            idle_on = 1'b1;
   bit            want_long_hold = 1'b0;
   int            cycle_count = 0;
   int            settings = 1;

   rectangle_canvas_painter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request of the given kind with every other field scrambled.
   function automatic rcp_req_type request_of(rcp_kind_type kind);
      logic [127:0] bits;
      rcp_req_type  rq;
      bits    = {$urandom, $urandom, $urandom, $urandom};
      rq      = bits[$bits(rcp_req_type)-1:0];
      rq.kind = kind;
      return rq;
   endfunction

   function automatic rcp_req_type read_at(int row, int col);
      rcp_req_type rq;
      rq          = request_of(REQ_READ);
      rq.read_row = RD_W'(row);
      rq.read_col = RD_W'(col);
      return rq;
   endfunction

   function automatic rcp_req_type rect(rcp_kind_type kind, int x, int y, int w, int h,
                                        int paint);
      rcp_req_type rq;
      rq             = request_of(kind);
      rq.rect_x      = COORD_W'(x);
      rq.rect_y      = COORD_W'(y);
      rq.rect_width  = COORD_W'(w);
      rq.rect_height = COORD_W'(h);
      rq.paint_char  = PIX_W'(paint);
      return rq;
   endfunction

   // Mostly reads and rectangles that land on the canvas, some rejects and noise.
   function automatic rcp_req_type random_request(int cols, int rows);
      rcp_req_type  rq;
      rcp_kind_type shape;
      int pick;
      shape = $urandom_range(0, 1) ? REQ_FILL : REQ_OUTLINE;
      pick  = $urandom_range(0, 99);
      if (pick < 2) begin
         rq = request_of(REQ_CLEAR);
      end else if (pick < 40) begin
         rq = read_at($urandom_range(0, (rows < MAX_SIDE - 1) ? rows + 1 : MAX_SIDE - 1),
                      $urandom_range(0, (cols < MAX_SIDE - 1) ? cols + 1 : MAX_SIDE - 1));
      end else if (pick < 75) begin
         rq = rect(shape,
                   int'($urandom_range(0, (cols + 4) * FIX_ONE)) - 2 * FIX_ONE,
                   int'($urandom_range(0, (rows + 4) * FIX_ONE)) - 2 * FIX_ONE,
                   int'($urandom_range(1, (cols + 2) * FIX_ONE)),
                   int'($urandom_range(1, (rows + 2) * FIX_ONE)),
                   int'($urandom_range(0, 255)));
      end else if (pick < 85) begin
         // Width or height not positive: the draw must be refused.
         rq = request_of(shape);
         if ($urandom_range(0, 1)) begin
            rq.rect_width = COORD_W'(-int'($urandom_range(0, 262144)));
         end else begin
            rq.rect_height = COORD_W'(-int'($urandom_range(0, 262144)));
         end
      end else begin
         rq = request_of(rcp_kind_type'($urandom_range(1, 3)));
      end
      return rq;
   endfunction

   // Offer one request word and hold it until the block takes it.
   task automatic send_request(input rcp_req_type rq);
      logic [REQ_DW-1:0] word;
      int gap;
      word = '0;
      word[X_LSB +: COORD_W]     = rq.rect_x;
      word[Y_LSB +: COORD_W]     = rq.rect_y;
      word[W_LSB +: COORD_W]     = rq.rect_width;
      word[H_LSB +: COORD_W]     = rq.rect_height;
      word[PAINT_LSB +: PIX_W]   = rq.paint_char;
      word[ROW_LSB +: RD_W]      = rq.read_row;
      word[COL_LSB +: RD_W]      = rq.read_col;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= rq.kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_request(rq);
   endtask

   // Stop offering and wait until every expected result word has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.set_register(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // New canvas setting, written only once the block has gone quiet.
   task automatic set_canvas(input int cols, input int rows, input int bg);
      wait_drained();
      write_register(REG_CANVAS_WIDTH, CFG_W'(cols));
      write_register(REG_CANVAS_HEIGHT, CFG_W'(rows));
      write_register(REG_BACKGROUND, CFG_W'(bg));
      settings++;
   endtask

   // Result side: check each accepted word, then pick the ready level for the next cycle.
   initial begin : result_side
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) tracker.check_result(rsp_tuser, rsp_tdata);
         @(negedge clock);
         if (want_long_hold) begin
            want_long_hold = 1'b0;
            hold_left      = HOLD_CYCLES - 1;
            rsp_tready    <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int k;
      int cols;
      int rows;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Default setting: the canvas should hold the reset background everywhere.
      send_request(read_at(0, 0));
      send_request(read_at(MAX_SIDE - 1, MAX_SIDE - 1));
      // Fractional corners on both a filled and an outlined rectangle.
      send_request(rect(REQ_FILL, -FIX_ONE / 2, FIX_ONE + FIX_ONE / 4,
                        10 * FIX_ONE + 3 * FIX_ONE / 4, 3 * FIX_ONE + FIX_ONE / 2, "R"));
      send_request(rect(REQ_OUTLINE, 2 * FIX_ONE + FIX_ONE / 2, -FIX_ONE,
                        20 * FIX_ONE, 12 * FIX_ONE, "r"));
      send_request(read_at(1, 0));
      send_request(read_at(2, 5));
      send_request(read_at(3, 9));
      send_request(read_at(10, 22));
      // Sizes that are not positive are refused.
      send_request(rect(REQ_FILL, 0, 0, 0, FIX_ONE, 255));
      send_request(rect(REQ_OUTLINE, 0, 0, FIX_ONE, -262144, 255));
      send_request(rect(REQ_FILL, 0, 0, -1, 0, 255));

      // No rows or columns in use: draws paint nothing, every read is outside.
      set_canvas(0, 0, 0);
      send_request(rect(REQ_FILL, 0, 0, 256 * FIX_ONE, 256 * FIX_ONE, 255));
      send_request(read_at(0, 0));
      send_request(request_of(REQ_CLEAR));

      // Oversized registers clip to the full store; coordinate extremes.
      set_canvas(511, 300, 255);
      send_request(read_at(MAX_SIDE - 1, MAX_SIDE - 1));
      send_request(rect(REQ_FILL, -262144, -262144, 262143, 262143, 255));
      send_request(rect(REQ_OUTLINE, 262143, 262143, 262143, 262143, 0));
      send_request(read_at(0, 0));
      send_request(read_at(0, 1));

      // Random phases on small or thin canvases to keep sweeps short.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               cols = MAX_SIDE;
               rows = $urandom_range(1, 2);
            end
            1: begin
               cols = $urandom_range(1, 3);
               rows = MAX_SIDE;
            end
            default: begin
               cols = $urandom_range(1, 24);
               rows = $urandom_range(1, 24);
            end
         endcase
         set_canvas(cols, rows, $urandom_range(0, 255));
         idle_on = (phase != 2) && (phase != 4);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 2 && k == PHASE_ITEMS / 3) begin
               // Receiver holds off while reads keep coming, so the input backs up.
               want_long_hold = 1'b1;
               repeat (8) send_request(read_at($urandom_range(0, rows - 1),
                                               $urandom_range(0, cols - 1)));
               // Sender pauses until the backlog has fully drained.
               wait_drained();
            end
            send_request(random_request(cols, rows));
         end
      end

      wait_drained();
      $display("Covered %0d canvas settings with %0d clears, %0d draws (%0d refused) and %0d reads.",
               settings, tracker.clears, tracker.draws, tracker.rejected, tracker.reads);
      $display("Checked %0d result words in %0d cycles, %0d mismatches.",
               tracker.checked, cycle_count, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
